// File: sv/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg
// Shared types, codes and defaults of the footprint mask placement filter.
// ----------------------------------------------------------------------------
package fmpf_pkg;

  localparam int unsigned DEF_MAX_GRID_SIDE = 64;
  localparam int unsigned DEF_MAX_FOOT_SIDE = 8;
  localparam int unsigned DEF_MAX_BATCH     = 65536;

  localparam int unsigned SIDE_W = 9;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned ROW_W  = 64;

  localparam logic [1:0] CMD_GRID  = 2'd0;
  localparam logic [1:0] CMD_FOOT  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  typedef enum logic [2:0] {
    REG_GRID_W  = 3'd0,
    REG_GRID_H  = 3'd1,
    REG_FOOT_W  = 3'd2,
    REG_FOOT_H  = 3'd3,
    REG_OUT_CAP = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [5:0]       row_index;
    logic [ROW_W-1:0] row_bits;
    logic [5:0]       anchor_x;
    logic [5:0]       anchor_y;
    logic             batch_end;
  } in_item_t;

  typedef struct packed {
    logic        fits;
    logic [15:0] candidate_index;
    logic [15:0] fit_rank;
    logic        status;
    logic        last;
  } out_item_t;

endpackage

// File: sv/fmpf_grid_mem.sv
// ----------------------------------------------------------------------------
// fmpf_grid_mem
// Buildable grid store: one write and one registered read per cycle, with a
// valid bit per row so unwritten rows read as unbuildable.
// ----------------------------------------------------------------------------
module fmpf_grid_mem #(
  parameter int unsigned DEPTH = fmpf_pkg::DEF_MAX_GRID_SIDE,
  parameter int unsigned COLS  = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [COLS-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [COLS-1:0] rdata_o
);

  logic [COLS-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [COLS-1:0] rdata_q;
  logic            rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: sv/fmpf_row_cmp.sv
// ----------------------------------------------------------------------------
// fmpf_row_cmp
// Shift-and-compare unit: places one footprint row at the anchor column and
// flags any set footprint cell over an unbuildable grid cell.
// ----------------------------------------------------------------------------
module fmpf_row_cmp #(
  parameter int unsigned COLS      = 64,
  parameter int unsigned FOOT_SIDE = fmpf_pkg::DEF_MAX_FOOT_SIDE
) (
  input  logic [FOOT_SIDE-1:0]        frow_i,
  input  logic [fmpf_pkg::SIDE_W-1:0] fw_i,
  input  logic [5:0]                  ax_i,
  input  logic [COLS-1:0]             grow_i,
  output logic                        fail_o
);

  logic [FOOT_SIDE-1:0]      mask;
  logic [COLS+FOOT_SIDE-1:0] need_wide;
  logic [COLS-1:0]           need;

  always_comb begin
    for (int i = 0; i < FOOT_SIDE; i++) begin
      mask[i] = fmpf_pkg::SIDE_W'(i) < fw_i;
    end
  end

  assign need_wide = (COLS+FOOT_SIDE)'(frow_i & mask) << ax_i;
  assign need      = need_wide[COLS-1:0];
  assign fail_o    = |(need & ~grow_i);

endmodule

// File: sv/footprint_mask_placement_filter.sv
// ----------------------------------------------------------------------------
// footprint_mask_placement_filter
// Grid and footprint mask store with an iterative per-row fit check.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on start while busy is low. Command 0 writes a grid row,
//   command 1 a footprint row; both complete at the accepting edge, give no
//   result and leave busy low. Command 3 is dropped.
//   Command 2 checks an anchor: busy stays high through a scan state, one grid
//   row read and compared per cycle through the shared shift-compare unit for
//   each footprint row, then a drain state for the last compare; an anchor
//   out of bounds goes straight to the drain state. The result is on result_o
//   with done_o high for one cycle right after busy falls, and the next item
//   may be started in the cycle the result shows.
//   The receiver cannot stall; each result is shown once.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at
//   once; write only while idle.
//   Reset clears the grid and footprint, the batch counters and restores the
//   register defaults. There is no clearing pass.
// ----------------------------------------------------------------------------
module footprint_mask_placement_filter #(
  parameter int unsigned MAX_GRID_SIDE = fmpf_pkg::DEF_MAX_GRID_SIDE,
  parameter int unsigned MAX_FOOT_SIDE = fmpf_pkg::DEF_MAX_FOOT_SIDE,
  parameter int unsigned MAX_BATCH     = fmpf_pkg::DEF_MAX_BATCH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  fmpf_pkg::in_item_t       item_i,
  output logic                     done_o,
  output fmpf_pkg::out_item_t      result_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [fmpf_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned SW   = fmpf_pkg::SIDE_W;
  localparam int unsigned COLS = (MAX_GRID_SIDE < 64) ? MAX_GRID_SIDE : 64;
  localparam int unsigned GA_W = $clog2(MAX_GRID_SIDE);
  localparam int unsigned FY_W = $clog2(MAX_FOOT_SIDE);
  localparam int unsigned CC_W = $clog2(MAX_BATCH);
  localparam int unsigned FC_W = $clog2(MAX_BATCH + 1);

  fmpf_pkg::state_e state_q, state_d;

  logic [6:0]  gw_q, gh_q;
  logic [3:0]  fw_q, fh_q;
  logic [15:0] cap_q;

  logic [SW-1:0] gw, gh, fw, fh;
  logic          accept, is_check, bound_ok, rd_en, fin;

  logic [MAX_FOOT_SIDE-1:0] foot_q [MAX_FOOT_SIDE];

  logic [5:0]      ax_q, ay_q;
  logic            end_q;
  logic [FY_W-1:0] y_q, cy_q;
  logic            pend_q, fail_q;
  logic            y_last;
  logic [SW-1:0]   raddr_wide, wrow_wide;
  logic            grid_we;
  logic [COLS-1:0] grow;
  logic            cmp_fail, fit;

  logic [CC_W-1:0] cand_q;
  logic [FC_W-1:0] fit_q;
  logic            ovf_q;
  logic [31:0]     cand_ext, fit_ext;
  logic            ovf_now;

  logic                done_q;
  fmpf_pkg::out_item_t res_q;

  // effective shape
  always_comb begin
    gw = (gw_q == '0) ? SW'(1) : ((SW'(gw_q) > SW'(COLS)) ? SW'(COLS) : SW'(gw_q));
    gh = (gh_q == '0) ? SW'(1) :
         ((SW'(gh_q) > SW'(MAX_GRID_SIDE)) ? SW'(MAX_GRID_SIDE) : SW'(gh_q));
    fw = (fw_q == '0) ? SW'(1) :
         ((SW'(fw_q) > SW'(MAX_FOOT_SIDE)) ? SW'(MAX_FOOT_SIDE) : SW'(fw_q));
    fh = (fh_q == '0) ? SW'(1) :
         ((SW'(fh_q) > SW'(MAX_FOOT_SIDE)) ? SW'(MAX_FOOT_SIDE) : SW'(fh_q));
    bound_ok = (fw <= gw) && (fh <= gh) &&
               (SW'(item_i.anchor_x) <= gw - fw) && (SW'(item_i.anchor_y) <= gh - fh);
  end

  assign busy     = state_q != fmpf_pkg::ST_IDLE;
  assign accept   = start && !busy;
  assign is_check = accept && (item_i.command == fmpf_pkg::CMD_CHECK);
  assign y_last   = SW'(y_q) == fh - SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q  <= 7'd64;
      gh_q  <= 7'd64;
      fw_q  <= 4'd1;
      fh_q  <= 4'd1;
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fmpf_pkg::REG_GRID_W:  gw_q  <= cfg_wdata_i[6:0];
        fmpf_pkg::REG_GRID_H:  gh_q  <= cfg_wdata_i[6:0];
        fmpf_pkg::REG_FOOT_W:  fw_q  <= cfg_wdata_i[3:0];
        fmpf_pkg::REG_FOOT_H:  fh_q  <= cfg_wdata_i[3:0];
        fmpf_pkg::REG_OUT_CAP: cap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FOOT_SIDE; i++) begin
        foot_q[i] <= '0;
      end
    end else if (accept && (item_i.command == fmpf_pkg::CMD_FOOT) &&
                 (SW'(item_i.row_index) < SW'(MAX_FOOT_SIDE))) begin
      foot_q[item_i.row_index[FY_W-1:0]] <= item_i.row_bits[MAX_FOOT_SIDE-1:0];
    end
  end

  assign wrow_wide  = SW'(item_i.row_index);
  assign grid_we    = accept && (item_i.command == fmpf_pkg::CMD_GRID) &&
                      (wrow_wide < SW'(MAX_GRID_SIDE));
  assign raddr_wide = SW'(ay_q) + SW'(y_q);

  fmpf_grid_mem #(
    .DEPTH (MAX_GRID_SIDE),
    .COLS  (COLS)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (grid_we),
    .waddr_i (wrow_wide[GA_W-1:0]),
    .wdata_i (item_i.row_bits[COLS-1:0]),
    .re_i    (rd_en),
    .raddr_i (raddr_wide[GA_W-1:0]),
    .rdata_o (grow)
  );

  fmpf_row_cmp #(
    .COLS      (COLS),
    .FOOT_SIDE (MAX_FOOT_SIDE)
  ) u_cmp (
    .frow_i (foot_q[cy_q]),
    .fw_i   (fw),
    .ax_i   (ax_q),
    .grow_i (grow),
    .fail_o (cmp_fail)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmpf_pkg::ST_IDLE: begin
        if (is_check) begin
          state_d = bound_ok ? fmpf_pkg::ST_SCAN : fmpf_pkg::ST_DRAIN;
        end
      end
      fmpf_pkg::ST_SCAN: begin
        if (y_last) begin
          state_d = fmpf_pkg::ST_DRAIN;
        end
      end
      fmpf_pkg::ST_DRAIN: state_d = fmpf_pkg::ST_IDLE;
      default:            state_d = fmpf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en = 1'b0;
    fin   = 1'b0;
    case (state_q)
      fmpf_pkg::ST_SCAN:  rd_en = 1'b1;
      fmpf_pkg::ST_DRAIN: fin   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmpf_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      fail_q  <= 1'b0;
      y_q     <= '0;
      cy_q    <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      cy_q    <= y_q;
      if (is_check) begin
        y_q    <= '0;
        fail_q <= !bound_ok;
      end else begin
        if (rd_en) begin
          y_q <= y_q + FY_W'(1);
        end
        if (pend_q && cmp_fail) begin
          fail_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_check) begin
      ax_q  <= item_i.anchor_x;
      ay_q  <= item_i.anchor_y;
      end_q <= item_i.batch_end;
    end
  end

  assign fit      = !(fail_q || (pend_q && cmp_fail));
  assign cand_ext = 32'(cand_q);
  assign fit_ext  = 32'(fit_q);
  assign ovf_now  = ovf_q || (fit && (fit_ext >= 32'(cap_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      fit_q  <= '0;
      ovf_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin;
      if (fin) begin
        if (end_q) begin
          cand_q <= '0;
          fit_q  <= '0;
          ovf_q  <= 1'b0;
        end else begin
          cand_q <= (cand_ext == 32'(MAX_BATCH - 1)) ? '0 : cand_q + CC_W'(1);
          if (fit && (fit_ext < 32'(MAX_BATCH))) begin
            fit_q <= fit_q + FC_W'(1);
          end
          ovf_q <= ovf_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_q.fits            <= fit;
      res_q.candidate_index <= cand_ext[15:0];
      res_q.fit_rank        <= (fit_ext > 32'd65535) ? 16'hFFFF : fit_ext[15:0];
      res_q.status          <= ovf_now;
      res_q.last            <= end_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: sv/fmpf_checker.sv
// ----------------------------------------------------------------------------
// fmpf_checker
// Port-level checks of the footprint mask placement filter, bound to the top.
// ----------------------------------------------------------------------------
module fmpf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input fmpf_pkg::in_item_t  item_i,
  input logic                done_o,
  input fmpf_pkg::out_item_t result_o
);

  a_check_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.command == fmpf_pkg::CMD_CHECK) |=> busy && !done_o)
    else $error("check item did not raise busy");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.command != fmpf_pkg::CMD_CHECK) |=> !busy && !done_o)
    else $error("write item produced busy or a result");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result not at end of a check");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_first_of_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.last |=> !done_o ##1 (!done_o || (result_o.candidate_index == 16'd0)))
    else $error("batch counters did not restart");

endmodule

bind footprint_mask_placement_filter fmpf_checker u_fmpf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// File: test/tb_footprint_mask_placement_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_footprint_mask_placement_filter
// Self-checking bench for the footprint placement filter. Loads grid and
// footprint rows, issues anchor checks in batches under several register
// settings and sender idle rates, and compares every result against an
// in-bench model of the fit test and the batch counters.
// ----------------------------------------------------------------------------
module tb_footprint_mask_placement_filter;

  localparam logic [1:0]  CMD_NONE      = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned LONG_BATCH    = 24;
  localparam int unsigned RW            = fmpf_pkg::ROW_W;
  localparam int unsigned CW            = fmpf_pkg::CFG_W;
  localparam int unsigned GRID_SIDE     = fmpf_pkg::DEF_MAX_GRID_SIDE;
  localparam int unsigned FOOT_SIDE     = fmpf_pkg::DEF_MAX_FOOT_SIDE;

  class placement_scoreboard;
    logic [RW-1:0]           grid_cells [GRID_SIDE];
    logic [7:0]              foot_cells [FOOT_SIDE];
    int unsigned             cand_count;
    int unsigned             fit_count;
    bit                      too_small;
    int unsigned             grid_w, grid_h, foot_w, foot_h, capacity;
    fmpf_pkg::out_item_t     expected_placements [$];
    int unsigned             mismatches;

    function new();
      foreach (grid_cells[i]) grid_cells[i] = '0;
      foreach (foot_cells[i]) foot_cells[i] = '0;
      cand_count  = 0;
      fit_count   = 0;
      too_small   = 1'b0;
      grid_w      = 64;
      grid_h      = 64;
      foot_w      = 1;
      foot_h      = 1;
      capacity    = 65535;
      mismatches  = 0;
    endfunction

    function int unsigned eff_side(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
    endfunction

    function int unsigned anchor_span(bit vertical);
      int unsigned g, f;
      g = vertical ? eff_side(grid_h, GRID_SIDE) : eff_side(grid_w, GRID_SIDE);
      f = vertical ? eff_side(foot_h, FOOT_SIDE) : eff_side(foot_w, FOOT_SIDE);
      return (f > g) ? 0 : g - f;
    endfunction

    function void write_reg(fmpf_pkg::cfg_idx_e idx, logic [CW-1:0] v);
      case (idx)
        fmpf_pkg::REG_GRID_W:  grid_w = 32'(v[6:0]);
        fmpf_pkg::REG_GRID_H:  grid_h = 32'(v[6:0]);
        fmpf_pkg::REG_FOOT_W:  foot_w = 32'(v[3:0]);
        fmpf_pkg::REG_FOOT_H:  foot_h = 32'(v[3:0]);
        fmpf_pkg::REG_OUT_CAP: capacity = 32'(v);
        default: ;
      endcase
    endfunction

    function bit placement_fits(int unsigned ax, int unsigned ay);
      int unsigned gw, gh, fw, fh;
      gw = eff_side(grid_w, GRID_SIDE);
      gh = eff_side(grid_h, GRID_SIDE);
      fw = eff_side(foot_w, FOOT_SIDE);
      fh = eff_side(foot_h, FOOT_SIDE);
      if (fw > gw || fh > gh) return 1'b0;
      if (ax > gw - fw || ay > gh - fh) return 1'b0;
      for (int unsigned y = 0; y < fh; y++) begin
        for (int unsigned x = 0; x < fw; x++) begin
          if (foot_cells[3'(y)][3'(x)] && !grid_cells[6'(ay + y)][6'(ax + x)]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_item(fmpf_pkg::in_item_t it);
      fmpf_pkg::out_item_t want;
      bit                  fit;
      case (it.command)
        fmpf_pkg::CMD_GRID: grid_cells[it.row_index] = it.row_bits;
        fmpf_pkg::CMD_FOOT: begin
          if (it.row_index < FOOT_SIDE) foot_cells[it.row_index[2:0]] = it.row_bits[7:0];
        end
        fmpf_pkg::CMD_CHECK: begin
          fit = placement_fits(32'(it.anchor_x), 32'(it.anchor_y));
          if (fit && fit_count >= capacity) too_small = 1'b1;
          want.fits            = fit;
          want.candidate_index = cand_count[15:0];
          want.fit_rank        = (fit_count > 65535) ? 16'hFFFF : fit_count[15:0];
          want.status          = too_small;
          want.last            = it.batch_end;
          expected_placements.push_back(want);
          if (fit && fit_count < fmpf_pkg::DEF_MAX_BATCH) fit_count++;
          cand_count = (cand_count + 1) % fmpf_pkg::DEF_MAX_BATCH;
          if (it.batch_end) begin
            cand_count = 0;
            fit_count  = 0;
            too_small  = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(fmpf_pkg::out_item_t got);
      fmpf_pkg::out_item_t want;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: fits=%0d idx=%0d rank=%0d status=%0d last=%0d",
                   got.fits, got.candidate_index, got.fit_rank, got.status, got.last);
        return;
      end
      want = expected_placements.pop_front();
      if (got.fits !== want.fits || got.candidate_index !== want.candidate_index ||
          got.fit_rank !== want.fit_rank || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: exp fits=%0d idx=%0d rank=%0d status=%0d last=%0d",
                   want.fits, want.candidate_index, want.fit_rank, want.status, want.last);
          $display("                 got fits=%0d idx=%0d rank=%0d status=%0d last=%0d",
                   got.fits, got.candidate_index, got.fit_rank, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  fmpf_pkg::in_item_t  cmd_item;
  logic                done_o;
  fmpf_pkg::out_item_t placement_result;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [CW-1:0]       cfg_wdata_i;

  placement_scoreboard sb = new();
  int unsigned         cycle_count = 0;

  footprint_mask_placement_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (cmd_item),
    .done_o      (done_o),
    .result_o    (placement_result),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(placement_result);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_footprint_mask_placement_filter: FAIL");
      $finish;
    end
  end

  function automatic logic [RW-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic fmpf_pkg::in_item_t random_item();
    fmpf_pkg::in_item_t it;
    it.command   = 2'($urandom_range(3));
    it.row_index = 6'($urandom_range(63));
    it.row_bits  = rand_row();
    it.anchor_x  = 6'($urandom_range(63));
    it.anchor_y  = 6'($urandom_range(63));
    it.batch_end = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic fmpf_pkg::in_item_t grid_write(int unsigned row, logic [RW-1:0] bits);
    fmpf_pkg::in_item_t it;
    it           = random_item();
    it.command   = fmpf_pkg::CMD_GRID;
    it.row_index = 6'(row);
    it.row_bits  = bits;
    return it;
  endfunction

  function automatic fmpf_pkg::in_item_t foot_write(int unsigned row, logic [RW-1:0] bits);
    fmpf_pkg::in_item_t it;
    it           = random_item();
    it.command   = fmpf_pkg::CMD_FOOT;
    it.row_index = 6'(row);
    it.row_bits  = bits;
    return it;
  endfunction

  function automatic fmpf_pkg::in_item_t anchor_check(int unsigned ax, int unsigned ay,
                                                      bit last);
    fmpf_pkg::in_item_t it;
    it           = random_item();
    it.command   = fmpf_pkg::CMD_CHECK;
    it.anchor_x  = 6'(ax);
    it.anchor_y  = 6'(ay);
    it.batch_end = last;
    return it;
  endfunction

  task automatic send_item(fmpf_pkg::in_item_t it);
    @(negedge clk_i);
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic hold_off(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_placements.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(fmpf_pkg::cfg_idx_e idx, logic [CW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
  endtask

  task automatic configure(int unsigned gw, int unsigned gh, int unsigned fw,
                           int unsigned fh, int unsigned cap);
    drain();
    write_cfg(fmpf_pkg::REG_GRID_W, CW'(gw));
    write_cfg(fmpf_pkg::REG_GRID_H, CW'(gh));
    write_cfg(fmpf_pkg::REG_FOOT_W, CW'(fw));
    write_cfg(fmpf_pkg::REG_FOOT_H, CW'(fh));
    write_cfg(fmpf_pkg::REG_OUT_CAP, CW'(cap));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned rand_grid_side();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(65, 127);
    return $urandom_range(1, 64);
  endfunction

  function automatic int unsigned rand_foot_side();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(9, 15);
    return $urandom_range(1, 8);
  endfunction

  function automatic int unsigned rand_capacity();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return $urandom_range(2, 6);
      3: return $urandom_range(65535);
      default: return 65535;
    endcase
  endfunction

  task automatic random_round(int unsigned pct);
    int unsigned        idle;
    int unsigned        ax, ay;
    logic [RW-1:0]      bits;
    fmpf_pkg::in_item_t it;
    idle = ($urandom_range(3) == 0) ? 0 : pct;
    configure(rand_grid_side(), rand_grid_side(), rand_foot_side(), rand_foot_side(),
              rand_capacity());
    for (int unsigned r = 0; r < FOOT_SIDE; r++) begin
      case ($urandom_range(3))
        0:       bits = '0;
        1, 2:    bits = rand_row() & rand_row();
        default: bits = rand_row();
      endcase
      send_item(foot_write(r, bits));
      hold_off(idle);
    end
    for (int unsigned n = 0; n < 16; n++) begin
      case ($urandom_range(3))
        0:       bits = '1;
        1, 2:    bits = rand_row() | rand_row() | rand_row();
        default: bits = rand_row();
      endcase
      send_item(grid_write($urandom_range(63), bits));
      hold_off(idle);
    end
    for (int unsigned n = 0; n < 26; n++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: begin
            it         = random_item();
            it.command = CMD_NONE;
          end
          1:       it = foot_write($urandom_range(8, 63), rand_row());
          default: it = grid_write($urandom_range(63), rand_row() | rand_row());
        endcase
        send_item(it);
        hold_off(idle);
      end
      if ($urandom_range(6) == 0) begin
        ax = $urandom_range(63);
        ay = $urandom_range(63);
      end else begin
        ax = $urandom_range(sb.anchor_span(1'b0));
        ay = $urandom_range(sb.anchor_span(1'b1));
      end
      send_item(anchor_check(ax, ay, ($urandom_range(7) == 0) || n == 25));
      hold_off(idle);
    end
  endtask

  initial begin
    int unsigned idle_rates [4];
    idle_rates  = '{0, 86, 0, 22};
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_item    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = fmpf_pkg::REG_GRID_W;
    cfg_wdata_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(anchor_check(0, 0, 1'b0));
    send_item(grid_write(63, '1));
    send_item(grid_write(0, 64'h8000_0000_0000_0000));
    send_item(foot_write(0, rand_row() | 64'h0000_0000_0000_00FF));
    send_item(foot_write(9, '0));
    begin
      fmpf_pkg::in_item_t junk;
      junk         = random_item();
      junk.command = CMD_NONE;
      send_item(junk);
    end
    send_item(anchor_check(63, 63, 1'b0));
    send_item(anchor_check(0, 0, 1'b0));
    send_item(anchor_check(63, 0, 1'b1));

    configure(0, 127, 15, 0, 0);
    send_item(anchor_check(0, 0, 1'b0));
    send_item(anchor_check(63, 63, 1'b1));

    configure(8, 1, 8, 1, 0);
    send_item(grid_write(0, '1));
    send_item(anchor_check(0, 0, 1'b0));
    send_item(anchor_check(1, 0, 1'b0));
    send_item(anchor_check(0, 0, 1'b1));

    configure(64, 64, 1, 1, 65535);
    send_item(grid_write(63, '1));
    for (int unsigned n = 0; n < LONG_BATCH; n++)
      send_item(anchor_check(63, 63, n == LONG_BATCH - 1));

    foreach (idle_rates[p]) begin
      for (int unsigned k = 0; k < 3; k++) random_round(idle_rates[p]);
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_placements.size() == 0) begin
      $display("tb_footprint_mask_placement_filter: PASS");
    end else begin
      $display("tb_footprint_mask_placement_filter: FAIL");
    end
    $finish;
  end

endmodule
